// ===== hdl/dual_token_bucket_rr_shaper_unit_macros.svh =====
// assertion macros for the shaper
`ifndef DUAL_TOKEN_BUCKET_RR_SHAPER_UNIT_MACROS_SVH
`define DUAL_TOKEN_BUCKET_RR_SHAPER_UNIT_MACROS_SVH

// checked only out of reset
`define DTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define DTB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/dtb_pkg.sv =====
package dtb_pkg;

  localparam int unsigned DEF_NUM_QUEUES  = 8;
  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned MAX_RES         = 8;

  localparam logic [31:0] RST_BURST_SIZE = 32'd98304;
  localparam logic [15:0] RST_MAX_UNIT   = 16'd12144;
  localparam logic [15:0] RST_MEAN_RATE  = 16'd1000;
  localparam logic [15:0] RST_PEAK_RATE  = 16'd10000;
  localparam logic [4:0]  RST_QLIMIT     = 5'd0;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_W      = 17;

  typedef enum logic [1:0] {
    CMD_FRAME  = 2'd0,
    CMD_REQ    = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BURST = 3'd0,
    CFG_MTU   = 3'd1,
    CFG_MEAN  = 3'd2,
    CFG_PEAK  = 3'd3,
    CFG_QLIM  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    EV_SENT = 1'b0,
    EV_DROP = 1'b1
  } ev_e;

  typedef struct packed {
    logic        ev;
    logic [2:0]  queue;
    logic [15:0] len;
    logic [15:0] tag;
  } res_t;

endpackage

// ===== hdl/dtb_if.sv =====
interface dtb_in_if;
  import dtb_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  queue_index;
  logic [15:0] frame_len;
  logic [15:0] frame_tag;

  modport source (output valid, cmd, queue_index, frame_len, frame_tag, input ready);
  modport sink (input valid, cmd, queue_index, frame_len, frame_tag, output ready);
endinterface

interface dtb_out_if;
  import dtb_pkg::*;
  logic        valid;
  logic        ready;
  logic        event_res;
  logic [2:0]  out_queue;
  logic [15:0] out_len;
  logic [15:0] out_tag;
  logic        last;

  modport source (output valid, event_res, out_queue, out_len, out_tag, last, input ready);
  modport sink (input valid, event_res, out_queue, out_len, out_tag, last, output ready);
endinterface

// ===== hdl/dual_token_bucket_rr_shaper_unit.sv =====
// Dual token bucket shaper with per-queue drop-tail FIFOs served round-robin.
// One transaction is processed at a time; results leave through an output
// register, one per cycle at best, the last of a transaction marked by last.
// Bucket state (mean, peak, last update, timer expiry) sits in a per-queue
// RAM and frames in a ring RAM, both with a registered read, so every
// bucket access is a read, refill, check and write-back sequence.
// An arrival to a non-empty queue or a drop needs no bucket check, an
// arrival to an empty queue runs the bucket check, and a failed check adds
// two passes of the serial divider. A request only counts as pending when
// nothing is eligible; otherwise it sends a head frame and, if its queue
// does not empty, checks the next head-of-queue frame, which may fail and
// run the divider. A tick scans every queue, checks the timer of each armed
// one and, on each expiry while requests are pending, sends a frame (at most 8).
// A held-off receiver stalls the block once two results are waiting.
module dual_token_bucket_rr_shaper_unit #(
  parameter int unsigned NUM_QUEUES  = dtb_pkg::DEF_NUM_QUEUES,
  parameter int unsigned QUEUE_DEPTH = dtb_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dtb_in_if.sink                         in_i,
  dtb_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [dtb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dtb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dtb_pkg::*;
  `include "dual_token_bucket_rr_shaper_unit_macros.svh"

  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned DW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FN = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned FA = (FN > 1) ? $clog2(FN) : 1;
  localparam int unsigned QM_W = 112;

  typedef enum logic [20:0] {
    ST_IDLE  = 21'h000001,
    ST_PUSH  = 21'h000002,
    ST_PUT   = 21'h000004,
    ST_FIN   = 21'h000008,
    ST_TSCAN = 21'h000010,
    ST_TRD   = 21'h000020,
    ST_TCMP  = 21'h000040,
    ST_TNEXT = 21'h000080,
    ST_TAKE  = 21'h000100,
    ST_FRD1  = 21'h000200,
    ST_FWORD = 21'h000400,
    ST_TCONT = 21'h000800,
    ST_FRD2  = 21'h001000,
    ST_FHL   = 21'h002000,
    ST_QRD   = 21'h004000,
    ST_QLD   = 21'h008000,
    ST_QSUM  = 21'h010000,
    ST_QCHK  = 21'h020000,
    ST_DIVM  = 21'h040000,
    ST_DIVP  = 21'h080000,
    ST_QWB   = 21'h100000
  } st_e;

  // configuration
  logic [31:0] burst_q;
  logic [15:0] mtu_q, mrate_q, prate_q;
  logic [4:0]  qlim_q;

  // control
  st_e         state_q, ret_q, post_q;
  logic [1:0]  cmd_q;
  logic [2:0]  qi3_q;
  logic [QW-1:0] cq_q, wq_q, scan_q, rr_q, qa_q;
  logic [15:0] len_q, tag_q, chk_len_q;
  logic        ctx_take_q;
  logic [3:0]  res_n_q;
  logic [15:0] pend_q;
  logic [31:0] now_q;

  logic [DW-1:0] head_q [NUM_QUEUES];
  logic [CW-1:0] cnt_q  [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] elig_q, armed_q, qv_q;

  // bucket working registers
  logic [31:0] mean_w_q, exp_w_q;
  logic [15:0] peak_w_q;
  logic [47:0] mprod_q, pprod_q;
  logic [DIV_W-1:0] dm_q, dvdp_q;
  logic [15:0] dvsp_q;

  // divider
  logic             div_start_q, div_done;
  logic [DIV_W-1:0] div_dvd_q, div_quo;
  logic [15:0]      div_dvs_q;

  // results
  res_t new_q, hold_q;
  logic hold_v_q;
  res_t out_q;
  logic ov_q, olast_q, out_free;

  // memories
  logic [QM_W-1:0] qmem [NUM_QUEUES];
  logic [QM_W-1:0] qm_rd_q;
  logic            qm_we;
  logic [31:0]     fmem [FN];
  logic [31:0]     fm_rd_q;
  logic [FA-1:0]   fa_q, fm_wa;
  logic            fm_we;

  // arbiter
  logic [NUM_QUEUES-1:0] rr_req;
  logic                  gnt_v;
  logic [QW-1:0]         gnt;

  // helpers
  logic [CW-1:0] lim;
  logic [31:0]   el, m0, l0, e0;
  logic [15:0]   p0, dmr, dpr;
  logic [48:0]   msum, psum;
  logic [31:0]   pushpos;
  logic [DW-1:0] head_inc;
  st_e           tend;

  always_comb begin
    if (qlim_q == 5'd0 || 32'(qlim_q) > QUEUE_DEPTH) lim = CW'(QUEUE_DEPTH);
    else lim = CW'(qlim_q);
  end

  always_comb begin
    for (int unsigned i = 0; i < NUM_QUEUES; i++) rr_req[i] = elig_q[i] && (cnt_q[i] != '0);
  end

  dtb_rr #(.NUM_QUEUES(NUM_QUEUES), .QW(QW)) u_rr (
    .req_i  (rr_req),
    .ptr_i  (rr_q),
    .gnt_v_o(gnt_v),
    .gnt_o  (gnt)
  );

  dtb_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(div_dvd_q),
    .divisor_i (div_dvs_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign dmr = (mrate_q == 16'd0) ? 16'd1 : mrate_q;
  assign dpr = (prate_q == 16'd0) ? 16'd1 : prate_q;

  // bucket entry fields, unwritten entries read as reset values
  assign m0 = qv_q[wq_q] ? qm_rd_q[31:0]   : RST_BURST_SIZE;
  assign p0 = qv_q[wq_q] ? qm_rd_q[47:32]  : RST_MAX_UNIT;
  assign l0 = qv_q[wq_q] ? qm_rd_q[79:48]  : 32'd0;
  assign e0 = qv_q[wq_q] ? qm_rd_q[111:80] : 32'd0;
  assign el = now_q - l0;

  assign msum = {17'd0, mean_w_q} + {1'b0, mprod_q};
  assign psum = {33'd0, peak_w_q} + {1'b0, pprod_q};

  assign pushpos = (32'(head_q[cq_q]) + 32'(cnt_q[cq_q]) >= QUEUE_DEPTH) ?
                   32'(head_q[cq_q]) + 32'(cnt_q[cq_q]) - QUEUE_DEPTH :
                   32'(head_q[cq_q]) + 32'(cnt_q[cq_q]);
  assign fm_wa    = FA'(32'(cq_q) * QUEUE_DEPTH + pushpos);
  assign fm_we    = (state_q == ST_PUSH);
  assign qm_we    = (state_q == ST_QWB);
  assign head_inc = (32'(head_q[gnt]) + 1 >= QUEUE_DEPTH) ? '0 : head_q[gnt] + 1'b1;
  assign tend     = (cmd_q == CMD_TICK) ? ST_TNEXT : ST_FIN;
  assign out_free = !ov_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    if (qm_we) qmem[wq_q] <= {exp_w_q, now_q, peak_w_q, mean_w_q};
    qm_rd_q <= qmem[qa_q];
  end

  always_ff @(posedge clk_i) begin
    if (fm_we) fmem[fm_wa] <= {tag_q, len_q};
    fm_rd_q <= fmem[fa_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= RST_BURST_SIZE;
      mtu_q   <= RST_MAX_UNIT;
      mrate_q <= RST_MEAN_RATE;
      prate_q <= RST_PEAK_RATE;
      qlim_q  <= RST_QLIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BURST: burst_q <= cfg_data_i;
        CFG_MTU:   mtu_q   <= cfg_data_i[15:0];
        CFG_MEAN:  mrate_q <= cfg_data_i[15:0];
        CFG_PEAK:  prate_q <= cfg_data_i[15:0];
        CFG_QLIM:  qlim_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      post_q      <= ST_IDLE;
      cmd_q       <= '0;
      qi3_q       <= '0;
      cq_q        <= '0;
      wq_q        <= '0;
      scan_q      <= '0;
      rr_q        <= '0;
      qa_q        <= '0;
      fa_q        <= '0;
      len_q       <= '0;
      tag_q       <= '0;
      chk_len_q   <= '0;
      ctx_take_q  <= 1'b0;
      res_n_q     <= '0;
      pend_q      <= '0;
      now_q       <= '0;
      elig_q      <= '0;
      armed_q     <= '0;
      qv_q        <= '0;
      mean_w_q    <= '0;
      peak_w_q    <= '0;
      exp_w_q     <= '0;
      mprod_q     <= '0;
      pprod_q     <= '0;
      dm_q        <= '0;
      dvdp_q      <= '0;
      dvsp_q      <= '0;
      div_start_q <= 1'b0;
      div_dvd_q   <= '0;
      div_dvs_q   <= '0;
      new_q       <= '0;
      hold_q      <= '0;
      hold_v_q    <= 1'b0;
      out_q       <= '0;
      ov_q        <= 1'b0;
      olast_q     <= 1'b0;
      for (int unsigned i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      div_start_q <= 1'b0;
      if (ov_q && out_o.ready) ov_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            cmd_q   <= in_i.cmd;
            qi3_q   <= in_i.queue_index;
            cq_q    <= QW'(in_i.queue_index);
            wq_q    <= QW'(in_i.queue_index);
            qa_q    <= QW'(in_i.queue_index);
            len_q   <= in_i.frame_len;
            tag_q   <= in_i.frame_tag;
            res_n_q <= '0;
            case (in_i.cmd)
              CMD_FRAME: begin
                new_q <= '{ev: EV_DROP, queue: in_i.queue_index,
                           len: in_i.frame_len, tag: in_i.frame_tag};
                ret_q <= ST_FIN;
                if (32'(in_i.queue_index) >= NUM_QUEUES) begin
                  state_q <= ST_PUT;
                end else if (cnt_q[QW'(in_i.queue_index)] != '0) begin
                  state_q <= (cnt_q[QW'(in_i.queue_index)] < lim) ? ST_PUSH : ST_PUT;
                end else begin
                  chk_len_q  <= in_i.frame_len;
                  ctx_take_q <= 1'b0;
                  state_q    <= ST_QRD;
                end
              end
              CMD_REQ:  state_q <= ST_TAKE;
              CMD_TICK: begin
                now_q   <= now_q + 32'd1;
                scan_q  <= '0;
                state_q <= ST_TSCAN;
              end
              default: state_q <= ST_FIN;
            endcase
          end
        end

        ST_PUSH: begin
          cnt_q[cq_q] <= cnt_q[cq_q] + 1'b1;
          state_q     <= ret_q;
        end

        ST_PUT: begin
          if (!hold_v_q) begin
            hold_q   <= new_q;
            hold_v_q <= 1'b1;
            state_q  <= ret_q;
          end else if (out_free) begin
            out_q   <= hold_q;
            olast_q <= 1'b0;
            ov_q    <= 1'b1;
            hold_q  <= new_q;
            state_q <= ret_q;
          end
        end

        ST_FIN: begin
          if (!hold_v_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_q    <= hold_q;
            olast_q  <= 1'b1;
            ov_q     <= 1'b1;
            hold_v_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end

        ST_TSCAN: begin
          qa_q    <= scan_q;
          wq_q    <= scan_q;
          state_q <= armed_q[scan_q] ? ST_TRD : ST_TNEXT;
        end

        ST_TRD: state_q <= ST_TCMP;

        ST_TCMP: begin
          state_q <= ST_TNEXT;
          if (e0 == now_q) begin
            armed_q[scan_q] <= 1'b0;
            if (cnt_q[scan_q] != '0) elig_q[scan_q] <= 1'b1;
            if (pend_q != 16'd0 && 32'(res_n_q) < MAX_RES) state_q <= ST_TAKE;
          end
        end

        ST_TNEXT: begin
          if (32'(scan_q) == NUM_QUEUES - 1) begin
            state_q <= ST_FIN;
          end else begin
            scan_q  <= scan_q + 1'b1;
            state_q <= ST_TSCAN;
          end
        end

        ST_TAKE: begin
          if (!gnt_v) begin
            if (cmd_q == CMD_REQ && pend_q != 16'hFFFF) pend_q <= pend_q + 16'd1;
            state_q <= tend;
          end else begin
            rr_q       <= gnt;
            wq_q       <= gnt;
            fa_q       <= FA'(32'(gnt) * QUEUE_DEPTH + 32'(head_q[gnt]));
            head_q[gnt] <= head_inc;
            cnt_q[gnt]  <= cnt_q[gnt] - 1'b1;
            if (cmd_q == CMD_TICK) pend_q <= pend_q - 16'd1;
            state_q <= ST_FRD1;
          end
        end

        ST_FRD1: state_q <= ST_FWORD;

        ST_FWORD: begin
          new_q   <= '{ev: EV_SENT, queue: 3'(wq_q), len: fm_rd_q[15:0],
                       tag: fm_rd_q[31:16]};
          res_n_q <= res_n_q + 4'd1;
          ret_q   <= ST_TCONT;
          state_q <= ST_PUT;
        end

        ST_TCONT: begin
          if (cnt_q[wq_q] != '0) begin
            fa_q    <= FA'(32'(wq_q) * QUEUE_DEPTH + 32'(head_q[wq_q]));
            state_q <= ST_FRD2;
          end else begin
            elig_q[wq_q] <= 1'b0;
            state_q      <= tend;
          end
        end

        ST_FRD2: state_q <= ST_FHL;

        ST_FHL: begin
          chk_len_q  <= fm_rd_q[15:0];
          ctx_take_q <= 1'b1;
          qa_q       <= wq_q;
          state_q    <= ST_QRD;
        end

        ST_QRD: state_q <= ST_QLD;

        ST_QLD: begin
          mean_w_q <= m0;
          peak_w_q <= p0;
          exp_w_q  <= e0;
          mprod_q  <= mrate_q * el;
          pprod_q  <= prate_q * el;
          state_q  <= ST_QSUM;
        end

        ST_QSUM: begin
          mean_w_q <= (msum > {17'd0, burst_q}) ? burst_q : msum[31:0];
          peak_w_q <= (psum > {33'd0, mtu_q}) ? mtu_q : psum[15:0];
          state_q  <= ST_QCHK;
        end

        ST_QCHK: begin
          if (32'(chk_len_q) <= mean_w_q && chk_len_q <= peak_w_q) begin
            mean_w_q <= mean_w_q - 32'(chk_len_q);
            peak_w_q <= peak_w_q - chk_len_q;
            state_q  <= ST_QWB;
            if (ctx_take_q) begin
              elig_q[wq_q] <= 1'b1;
              post_q       <= tend;
            end else if (pend_q != 16'd0) begin
              pend_q <= pend_q - 16'd1;
              rr_q   <= wq_q;
              new_q  <= '{ev: EV_SENT, queue: qi3_q, len: len_q, tag: tag_q};
              ret_q  <= ST_FIN;
              post_q <= ST_PUT;
            end else begin
              elig_q[wq_q] <= 1'b1;
              ret_q        <= ST_FIN;
              post_q       <= ST_PUSH;
            end
          end else begin
            elig_q[wq_q] <= 1'b0;
            ret_q        <= ST_FIN;
            post_q       <= ctx_take_q ? tend : ST_PUSH;
            div_start_q  <= 1'b1;
            div_dvs_q    <= dmr;
            div_dvd_q    <= (32'(chk_len_q) > mean_w_q) ?
                            DIV_W'(32'(chk_len_q) - mean_w_q) + DIV_W'(dmr) - 1'b1 : '0;
            dvsp_q       <= dpr;
            dvdp_q       <= (chk_len_q > peak_w_q) ?
                            DIV_W'(chk_len_q - peak_w_q) + DIV_W'(dpr) - 1'b1 : '0;
            state_q      <= ST_DIVM;
          end
        end

        ST_DIVM: begin
          if (div_done) begin
            dm_q        <= div_quo;
            div_start_q <= 1'b1;
            div_dvd_q   <= dvdp_q;
            div_dvs_q   <= dvsp_q;
            state_q     <= ST_DIVP;
          end
        end

        ST_DIVP: begin
          if (div_done) begin
            exp_w_q       <= now_q + 32'((dm_q > div_quo) ? dm_q : div_quo);
            armed_q[wq_q] <= 1'b1;
            state_q       <= ST_QWB;
          end
        end

        ST_QWB: begin
          qv_q[wq_q] <= 1'b1;
          state_q    <= post_q;
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = ov_q;
  assign out_o.event_res = out_q.ev;
  assign out_o.out_queue = out_q.queue;
  assign out_o.out_len   = out_q.len;
  assign out_o.out_tag   = out_q.tag;
  assign out_o.last      = olast_q;

  `DTB_ASSERT(a_idle_no_hold, (state_q == ST_IDLE) |-> !hold_v_q, "result left behind at idle")
  `DTB_ASSERT(a_res_bound, (32'(res_n_q) <= MAX_RES), "too many results in one tick")
  `DTB_ASSERT(a_pend_no_wrap, ($past(pend_q) == 16'hFFFF) |-> (pend_q != 16'd0), "pending wrapped")
  `DTB_ASSERT_ALWAYS(a_div_idle, (state_q == ST_IDLE) |-> !div_start_q, "divider started at idle")
endmodule

// ===== hdl/dtb_div.sv =====
module dtb_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dtb_pkg::DIV_W-1:0] dividend_i,
  input  logic [15:0]               divisor_i,
  output logic                      done_o,
  output logic [dtb_pkg::DIV_W-1:0] quotient_o
);
  import dtb_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_q, quo_q;
  logic [15:0]      dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DIV_W-1:0] rs;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign rs = {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
  assign ge = rs >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
        cnt_q  <= CNT_W'(DIV_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? rs - {1'b0, dvs_q} : rs;
        quo_q <= {quo_q[DIV_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

// ===== hdl/dtb_rr.sv =====
module dtb_rr #(
  parameter int unsigned NUM_QUEUES = dtb_pkg::DEF_NUM_QUEUES,
  parameter int unsigned QW         = 3
) (
  input  logic [NUM_QUEUES-1:0] req_i,
  input  logic [QW-1:0]         ptr_i,
  output logic                  gnt_v_o,
  output logic [QW-1:0]         gnt_o
);
  import dtb_pkg::*;

  int unsigned idx;

  // first requester after the pointer, wrapping
  always_comb begin
    gnt_v_o = 1'b0;
    gnt_o   = '0;
    idx     = 0;
    for (int unsigned i = 0; i < NUM_QUEUES; i++) begin
      idx = 32'(ptr_i) + 1 + i;
      if (idx >= NUM_QUEUES) idx = idx - NUM_QUEUES;
      if (!gnt_v_o && req_i[QW'(idx)]) begin
        gnt_v_o = 1'b1;
        gnt_o   = QW'(idx);
      end
    end
  end
endmodule
